>>> rtl/bqsf_pkg.sv
// Shared types and constants for the bounded queue server finish-time unit.
`timescale 1ns / 1ps
package bqsf_pkg;

  localparam int ID_W   = 32;
  localparam int TIME_W = 40;
  localparam int IN_W   = 32;
  localparam int LIM_W  = 6;
  localparam int CMP_W  = 7;

  localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};
  localparam logic [LIM_W-1:0]  LIMIT_RESET   = 6'd32;
  localparam logic              CMD_ARRIVE    = 1'b0;
  localparam logic              CMD_FLUSH     = 1'b1;
  localparam logic              REG_QUEUE_LIM = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DISPATCH,
    ST_START,
    ST_EMIT
  } bqsf_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // latch input item
    logic rd;        // read queue head
    logic pop;       // run head task, update busy time
    logic start;     // new task starts at once
    logic enq;       // write new task at tail
    logic drop;      // report new task as dropped
    logic emit;      // load output register
  } bqsf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic flush;
    logic dispatch_ok;
    logic can_start;
    logic has_room;
    logic res_final;
    logic out_free;
  } bqsf_sts_t;

  typedef struct packed {
    logic [IN_W-1:0] arrival;
    logic [IN_W-1:0] duration;
    logic [ID_W-1:0] id;
  } bqsf_entry_t;

endpackage

>>> rtl/bqsf_in_if.sv
// Handshake channel carrying input items.
`timescale 1ns / 1ps
interface bqsf_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] arrival_time;
  logic [31:0] task_duration;

  modport source (output valid, command, arrival_time, task_duration, input ready);
  modport sink   (input valid, command, arrival_time, task_duration, output ready);
endinterface

>>> rtl/bqsf_out_if.sv
// Handshake channel carrying result items.
`timescale 1ns / 1ps
interface bqsf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] task_id;
  logic [39:0] done_time;
  logic        dropped;
  logic        last;

  modport source (output valid, task_id, done_time, dropped, last, input ready);
  modport sink   (input valid, task_id, done_time, dropped, last, output ready);
endinterface

>>> rtl/bqsf_ctrl.sv
// Sequencing state machine: admission, dispatch and result emission.
`timescale 1ns / 1ps
module bqsf_ctrl
  import bqsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bqsf_sts_t sts,
  output bqsf_cmd_t cmd
);

  bqsf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (sts.dispatch_ok) state_nxt = ST_DISPATCH;
        else if (sts.flush)           state_nxt = ST_IDLE;
        else if (sts.can_start)       state_nxt = ST_START;
        else if (sts.has_room)        state_nxt = ST_IDLE;
        else                          state_nxt = ST_EMIT;
      end
      ST_DISPATCH: state_nxt = ST_EMIT;
      ST_START:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = sts.res_final ? ST_IDLE : ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHECK: begin
        priority if (sts.dispatch_ok) cmd.rd = 1'b1;
        else if (sts.flush)           cmd.rd = 1'b0;
        else if (sts.can_start)       cmd.rd = 1'b0;
        else if (sts.has_room)        cmd.enq = 1'b1;
        else                          cmd.drop = 1'b1;
      end
      ST_DISPATCH: cmd.pop   = 1'b1;
      ST_START:    cmd.start = 1'b1;
      ST_EMIT:     cmd.emit  = sts.out_free;
      default:     cmd       = '0;
    endcase
  end

endmodule

>>> rtl/bqsf_dpath.sv
// Datapath: waiting queue memory, server busy time, task ids, output register.
`timescale 1ns / 1ps
module bqsf_dpath
  import bqsf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bqsf_cmd_t         cmd,
  output bqsf_sts_t         sts,
  input  logic              in_command,
  input  logic [IN_W-1:0]   in_arrival_time,
  input  logic [IN_W-1:0]   in_task_duration,
  input  logic [LIM_W-1:0]  queue_limit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_task_id,
  output logic [TIME_W-1:0] out_done_time,
  output logic              out_dropped,
  output logic              out_last
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  bqsf_entry_t mem [QUEUE_DEPTH];
  bqsf_entry_t rd_data_r;

  logic [IDX_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0]  count_r;
  logic [TIME_W-1:0] busy_r;
  logic [ID_W-1:0]   next_id_r, cur_id_r, res_id_r;
  logic              flush_r, res_drop_r, res_final_r;
  logic [IN_W-1:0]   t_r, dur_r;
  logic              out_valid_r;

  logic [TIME_W-1:0] t_ext, arr_ext, base, fin;
  logic [IN_W-1:0]   add_dur;
  logic [TIME_W:0]   sum;
  logic              busy_le_t, has_room, last_val;

  assign t_ext     = {{(TIME_W-IN_W){1'b0}}, t_r};
  assign arr_ext   = {{(TIME_W-IN_W){1'b0}}, rd_data_r.arrival};
  assign busy_le_t = (busy_r <= t_ext);
  assign has_room  = (CMP_W'(count_r) < CMP_W'(queue_limit)) &&
                     (CMP_W'(count_r) < CMP_W'(QUEUE_DEPTH));

  // shared start + duration adder, saturating at the field maximum
  always_comb begin
    if (cmd.start) begin
      base    = t_ext;
      add_dur = dur_r;
    end else begin
      base    = (busy_r > arr_ext) ? busy_r : arr_ext;
      add_dur = rd_data_r.duration;
    end
    sum = {1'b0, base} + {{(TIME_W+1-IN_W){1'b0}}, add_dur};
    fin = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  end

  // a dispatch result is last if nothing follows: queue emptied on flush,
  // or on arrival the new task neither starts nor gets dropped
  assign last_val = flush_r ? (count_r == '0)
                            : (res_final_r || (!busy_le_t && has_room));

  assign sts.flush       = flush_r;
  assign sts.dispatch_ok = (count_r != '0) && (flush_r || busy_le_t);
  assign sts.can_start   = (count_r == '0) && busy_le_t;
  assign sts.has_room    = has_room;
  assign sts.res_final   = res_final_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  // queue store
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      mem[tail_r] <= '{arrival: t_r, duration: dur_r, id: cur_id_r};
    end
    if (cmd.rd) begin
      rd_data_r <= mem[head_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      busy_r      <= '0;
      next_id_r   <= '0;
      res_final_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && in_command == CMD_ARRIVE) next_id_r <= next_id_r + 1'b1;
      if (cmd.enq) begin
        tail_r  <= (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (cmd.pop) begin
        head_r      <= (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
        count_r     <= count_r - 1'b1;
        busy_r      <= fin;
        res_final_r <= 1'b0;
      end
      if (cmd.start) begin
        busy_r      <= fin;
        res_final_r <= 1'b1;
      end
      if (cmd.drop) res_final_r <= 1'b1;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flush_r  <= in_command;
      t_r      <= in_arrival_time;
      dur_r    <= in_task_duration;
      cur_id_r <= next_id_r;
    end
    if (cmd.pop) begin
      res_id_r   <= rd_data_r.id;
      res_drop_r <= 1'b0;
    end
    if (cmd.start) begin
      res_id_r   <= cur_id_r;
      res_drop_r <= 1'b0;
    end
    if (cmd.drop) begin
      res_id_r   <= cur_id_r;
      res_drop_r <= 1'b1;
    end
    if (cmd.emit) begin
      out_task_id   <= res_id_r;
      out_done_time <= res_drop_r ? '0 : busy_r;
      out_dropped   <= res_drop_r;
      out_last      <= last_val;
    end
  end

  assign out_valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq |-> CMP_W'(count_r) < CMP_W'(QUEUE_DEPTH))
    else $error("enqueue into full queue");

  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> count_r != '0)
    else $error("head read from empty queue");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_busy_mono: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> busy_r >= $past(busy_r))
    else $error("server free time moved backward");

endmodule

>>> rtl/bounded_queue_server_finish_times_unit.sv
// Top level: single-server FIFO queue with tail drop, config register and channels.
`timescale 1ns / 1ps
// One server with a FIFO waiting queue of QUEUE_DEPTH entries (a single-port
// memory, one head read per dispatch). Each arriving task first dispatches
// every waiting task the server can start by its arrival, then starts at once,
// waits in the queue or is reported dropped when queue_limit tasks wait; a
// flush item dispatches the whole queue. Items are handled one at a time by
// the controller, which accepts and checks each one; every task it
// dispatches then takes a head read, a finish-time add and an output load,
// a new task that starts at once a finish-time add and an output load, and a
// dropped one an output load; stalls on the result channel hold it. Results
// carry the task id and come in dispatch order; last marks the final result
// of an item. queue_limit sits at byte address 0 of the APB-style port and
// resets to 32; limits above QUEUE_DEPTH act as QUEUE_DEPTH.
module bounded_queue_server_finish_times_unit
  import bqsf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bqsf_in_if.sink     in_if,
  bqsf_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bqsf_cmd_t        cmd;
  bqsf_sts_t        sts;
  logic [LIM_W-1:0] queue_limit_r;
  logic             in_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_QUEUE_LIM) begin
      queue_limit_r <= pwdata[LIM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_QUEUE_LIM) ? {{(32-LIM_W){1'b0}}, queue_limit_r} : '0;

  assign in_if.ready = in_ready;

  bqsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bqsf_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_if.command),
    .in_arrival_time  (in_if.arrival_time),
    .in_task_duration (in_if.task_duration),
    .queue_limit      (queue_limit_r),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_task_id      (out_if.task_id),
    .out_done_time    (out_if.done_time),
    .out_dropped      (out_if.dropped),
    .out_last         (out_if.last)
  );

endmodule

>>> tb/tb_bounded_queue_server_finish_times_unit.sv
// Testbench for the bounded queue server unit: scoreboarded random and directed traffic.
`timescale 1ns / 1ps
module tb_bounded_queue_server_finish_times_unit;
  import bqsf_pkg::*;

  localparam int DEPTH = 32;

  typedef struct {
    logic        cmd;
    logic [31:0] arrival;
    logic [31:0] duration;
    int unsigned gap;
    bit          drain;    // hold the transfer until no result is outstanding
  } job_t;

  typedef struct {
    logic [31:0] task_id;
    logic [39:0] finish;
    logic        dropped;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bqsf_in_if  in_ch ();
  bqsf_out_if out_ch ();

  bounded_queue_server_finish_times_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // server model state
  logic [31:0] wait_arr [DEPTH];
  logic [31:0] wait_dur [DEPTH];
  logic [31:0] wait_id  [DEPTH];
  int          wait_head;
  int          wait_count;
  logic [39:0] busy_until;
  logic [31:0] next_id;
  logic [5:0]  queue_limit_cfg;

  result_t     finish_due [$];
  job_t        pending [$];
  int          mismatches;

  // driver / monitor state
  job_t        cur_job;
  bit          loaded;
  bit          offering;
  int          gap_left;
  int          owed;
  bit          in_quiet;
  bit          out_quiet;
  int          stall_left;
  logic [31:0] cursor;

  function automatic logic [39:0] finish_at(input logic [39:0] start, input logic [31:0] dur);
    logic [40:0] sum;
    sum = {1'b0, start} + {9'd0, dur};
    return sum[40] ? TIME_MAX : sum[39:0];
  endfunction

  function automatic void run_waiting_head();
    logic [39:0] arr40;
    logic [39:0] start;
    arr40 = {8'd0, wait_arr[wait_head]};
    start = (busy_until > arr40) ? busy_until : arr40;
    busy_until = finish_at(start, wait_dur[wait_head]);
    finish_due.push_back('{wait_id[wait_head], busy_until, 1'b0, 1'b0});
    wait_head = (wait_head + 1) % DEPTH;
    wait_count--;
  endfunction

  // returns how many results the item causes
  function automatic int predict_results(input job_t j);
    int          mark;
    int          lim;
    int          tail;
    logic [31:0] tid;
    logic [39:0] t40;
    result_t     tail_res;
    mark = finish_due.size();
    t40 = {8'd0, j.arrival};
    if (j.cmd == CMD_FLUSH) begin
      while (wait_count > 0) run_waiting_head();
    end else begin
      tid = next_id;
      next_id = next_id + 32'd1;
      lim = (queue_limit_cfg > DEPTH) ? DEPTH : int'(queue_limit_cfg);
      while (wait_count > 0 && busy_until <= t40) run_waiting_head();
      if (wait_count == 0 && busy_until <= t40) begin
        busy_until = finish_at(t40, j.duration);
        finish_due.push_back('{tid, busy_until, 1'b0, 1'b0});
      end else if (wait_count < lim) begin
        tail = (wait_head + wait_count) % DEPTH;
        wait_arr[tail] = j.arrival;
        wait_dur[tail] = j.duration;
        wait_id[tail] = tid;
        wait_count++;
      end else begin
        finish_due.push_back('{tid, 40'd0, 1'b1, 1'b0});
      end
    end
    if (finish_due.size() > mark) begin
      tail_res = finish_due.pop_back();
      tail_res.last = 1'b1;
      finish_due.push_back(tail_res);
    end
    return finish_due.size() - mark;
  endfunction

  function automatic void push_job(input logic cmd, input logic [31:0] arr,
                                   input logic [31:0] dur, input bit drain);
    job_t j;
    if ($urandom_range(0, 14) == 0) in_quiet = !in_quiet;
    j.cmd = cmd;
    j.arrival = arr;
    j.duration = dur;
    j.gap = in_quiet ? 0 : $urandom_range(0, 4);
    j.drain = drain;
    pending.push_back(j);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      loaded = 1'b0;
      offering = 1'b0;
      gap_left = 0;
      owed = 0;
    end else begin
      if (out_ch.valid && out_ch.ready && owed > 0) owed--;
      if (in_ch.valid && in_ch.ready) begin
        owed += predict_results(cur_job);
        loaded = 1'b0;
        offering = 1'b0;
      end
      if (!loaded && pending.size() != 0) begin
        cur_job = pending.pop_front();
        loaded = 1'b1;
        gap_left = cur_job.gap;
      end
      if (loaded && !offering) begin
        if (gap_left > 0) gap_left--;
        else if (!cur_job.drain || owed == 0) offering = 1'b1;
      end
      in_ch.valid <= offering;
      if (offering) begin
        in_ch.command <= cur_job.cmd;
        in_ch.arrival_time <= cur_job.arrival;
        in_ch.task_duration <= cur_job.duration;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (finish_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: id=%0d finish=%0d dropped=%b last=%b",
                     $realtime, out_ch.task_id, out_ch.done_time, out_ch.dropped,
                     out_ch.last);
        end else begin
          exp_res = finish_due.pop_front();
          if (out_ch.task_id !== exp_res.task_id || out_ch.done_time !== exp_res.finish ||
              out_ch.dropped !== exp_res.dropped || out_ch.last !== exp_res.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected id=%0d finish=%0d dropped=%b last=%b",
                       $realtime, exp_res.task_id, exp_res.finish, exp_res.dropped,
                       exp_res.last);
              $display("    got id=%0d finish=%0d dropped=%b last=%b",
                       out_ch.task_id, out_ch.done_time, out_ch.dropped, out_ch.last);
            end
          end
        end
        if ($urandom_range(0, 19) == 0) out_quiet = !out_quiet;
        stall_left = out_quiet ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // wait until every item is taken and every result is in, then let the block finish up
  task automatic settle();
    @(negedge clk);
    while (pending.size() != 0 || loaded || owed != 0 || finish_due.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_queue_limit(input logic [5:0] v);
    settle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_QUEUE_LIM);
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    queue_limit_cfg = v;
  endtask

  // mostly a rising arrival timeline so the server both idles and backs up
  task automatic random_phase(input logic [5:0] lim, input int unsigned dur_max,
                              input logic [31:0] base, input int n);
    int unsigned pick;
    set_queue_limit(lim);
    if (cursor < base) cursor = base;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_job(CMD_FLUSH, $urandom, $urandom, $urandom_range(0, 59) == 0);
      end else if (pick < 16) begin
        push_job(CMD_ARRIVE, $urandom_range(0, cursor), $urandom_range(1, dur_max), 1'b0);
      end else begin
        cursor = cursor + $urandom_range(0, 45);
        push_job(CMD_ARRIVE, cursor, $urandom_range(1, dur_max),
                 $urandom_range(0, 59) == 0);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ARRIVE;
    in_ch.arrival_time = '0;
    in_ch.task_duration = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    wait_head = 0;
    wait_count = 0;
    busy_until = '0;
    next_id = '0;
    queue_limit_cfg = LIMIT_RESET;
    mismatches = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    cursor = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: arrival exactly at free time, empty flush, zero duration,
    // multi-dispatch on one arrival, earlier arrival than the last one
    push_job(CMD_ARRIVE, 32'd0, 32'd5, 1'b0);
    push_job(CMD_FLUSH, 32'd0, 32'd0, 1'b0);
    push_job(CMD_ARRIVE, 32'd2, 32'd3, 1'b0);
    push_job(CMD_ARRIVE, 32'd3, 32'd0, 1'b0);
    push_job(CMD_ARRIVE, 32'd5, 32'd4, 1'b1);
    push_job(CMD_ARRIVE, 32'd20, 32'd1, 1'b0);
    push_job(CMD_ARRIVE, 32'd21, 32'd2, 1'b0);
    push_job(CMD_ARRIVE, 32'd10, 32'd7, 1'b0);
    push_job(CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // limit zero: anything that cannot start at once is dropped
    set_queue_limit(6'd0);
    push_job(CMD_ARRIVE, 32'd25, 32'd3, 1'b0);
    push_job(CMD_ARRIVE, 32'd30, 32'd3, 1'b0);
    push_job(CMD_ARRIVE, 32'd31, 32'd1, 1'b0);
    set_queue_limit(6'd1);
    push_job(CMD_ARRIVE, 32'd32, 32'd1, 1'b0);
    push_job(CMD_ARRIVE, 32'd32, 32'd1, 1'b0);
    push_job(CMD_ARRIVE, 32'd40, 32'd2, 1'b0);
    set_queue_limit(6'd2);
    push_job(CMD_ARRIVE, 32'd41, 32'd1, 1'b0);
    push_job(CMD_ARRIVE, 32'd41, 32'd1, 1'b0);
    push_job(CMD_ARRIVE, 32'd41, 32'd1, 1'b0);
    push_job(CMD_FLUSH, 32'd0, 32'd0, 1'b0);

    random_phase(6'd32, 40, 32'h0000_0000, 21);
    random_phase(6'd1, 60, 32'h2A00_0000, 21);
    random_phase(6'd4, 90, 32'h5400_0000, 21);
    random_phase(6'd63, 70, 32'h7E00_0000, 21);
    random_phase(6'd0, 50, 32'hA800_0000, 21);
    random_phase(6'd17, 120, 32'hD200_0000, 21);

    // extremes last: after these the server never frees before any arrival,
    // and the finish time is driven into saturation
    set_queue_limit(6'd32);
    push_job(CMD_ARRIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_job(CMD_ARRIVE, 32'd0, 32'hFFFF_FFFF, 1'b0);
    push_job(CMD_FLUSH, 32'd0, 32'd0, 1'b0);
    set_queue_limit(6'd63);
    repeat (8) begin
      repeat (33) push_job(CMD_ARRIVE, $urandom, 32'hFFFF_FFFF, 1'b0);
      push_job(CMD_FLUSH, $urandom, $urandom, 1'b0);
    end

    settle();
    repeat (10) @(posedge clk);
    if (finish_due.size() != 0) begin
      $display("%0d expected results never arrived", finish_due.size());
      mismatches += finish_due.size();
    end
    if (mismatches == 0)
      $display("tb_bounded_queue_server_finish_times_unit: PASS");
    else
      $display("tb_bounded_queue_server_finish_times_unit: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_bounded_queue_server_finish_times_unit: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/bqsf_pkg.sv
rtl/bqsf_in_if.sv
rtl/bqsf_out_if.sv
rtl/bqsf_ctrl.sv
rtl/bqsf_dpath.sv
rtl/bounded_queue_server_finish_times_unit.sv
tb/tb_bounded_queue_server_finish_times_unit.sv
